/* rtl/core/sit_pkg.sv */
// Shared constants and types for the segment intersection block.
// Used by every module under rtl/core; no dependencies.
package sit_pkg;

   // Default coordinate width (signed, 4 fraction bits)
   localparam int COORD_BITS_DEF = 16;

   // CSR index width and register map
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_START_X = 2'd0,
      REG_START_Y = 2'd1,
      REG_END_X   = 2'd2,
      REG_END_Y   = 2'd3
   } reg_idx_type;

endpackage

/* rtl/core/sit_front.sv */
// Front pipeline: differences, products, cross products, sign normalize,
// hit test and numerator multiply (five stages). Depends on sit_pkg.
module sit_front import sit_pkg::*; #(
   parameter int W = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   p0x,
   input  logic signed [W-1:0]   p0y,
   input  logic signed [W-1:0]   p1x,
   input  logic signed [W-1:0]   p1y,
   input  logic signed [W-1:0]   ax0,
   input  logic signed [W-1:0]   ay0,
   input  logic signed [W:0]     dx,
   input  logic signed [W:0]     dy,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  hit,
   output logic                  negx,
   output logic                  negy,
   output logic [3*W+3:0]        magx,
   output logic [3*W+3:0]        magy,
   output logic [2*W+3:0]        dn
);
   localparam int DW  = W + 1;      // coordinate difference
   localparam int PW  = 2 * DW;     // product
   localparam int CW  = PW + 1;     // cross product
   localparam int DNW = CW + 1;     // denominator
   localparam int NS  = 5;

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   assign rdy[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 0: relative positions and probe direction
   logic signed [DW-1:0] r0x_ff, r0y_ff, r1x_ff, r1y_ff, ex_ff, ey_ff;
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         r0x_ff <= DW'(p0x) - DW'(ax0);
         r0y_ff <= DW'(p0y) - DW'(ay0);
         r1x_ff <= DW'(p1x) - DW'(ax0);
         r1y_ff <= DW'(p1y) - DW'(ay0);
         ex_ff  <= DW'(p1x) - DW'(p0x);
         ey_ff  <= DW'(p1y) - DW'(p0y);
      end
   end

   // stage 1: six products
   logic signed [PW-1:0] p0a_ff, p0b_ff, p1a_ff, p1b_ff, ga_ff, gb_ff;
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         p0a_ff <= dx * r0y_ff;
         p0b_ff <= dy * r0x_ff;
         p1a_ff <= dx * r1y_ff;
         p1b_ff <= dy * r1x_ff;
         ga_ff  <= ey_ff * r0x_ff;
         gb_ff  <= ex_ff * r0y_ff;
      end
   end

   // stage 2: side values c0, c1 and crossing parameter g
   logic signed [CW-1:0] c0_ff, c1_ff, g_ff;
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         c0_ff <= CW'(p0a_ff) - CW'(p0b_ff);
         c1_ff <= CW'(p1a_ff) - CW'(p1b_ff);
         g_ff  <= CW'(ga_ff) - CW'(gb_ff);
      end
   end

   // stage 3: straddle test on c0, c1 and make the denominator positive
   logic signed [DNW-1:0] den_in;
   logic                  cand_ff;
   logic [DNW-1:0]        dn_ff;
   logic signed [DNW-1:0] gn_ff;
   assign den_in = DNW'(c1_ff) - DNW'(c0_ff);
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         cand_ff <= c0_ff[CW-1] != c1_ff[CW-1];
         dn_ff   <= den_in[DNW-1] ? DNW'(-den_in) : DNW'(den_in);
         gn_ff   <= den_in[DNW-1] ? -DNW'(g_ff) : DNW'(g_ff);
      end
   end

   // stage 4: range check on g and numerator magnitudes
   logic [W-1:0]       dxa, dya;
   logic [W+DNW-1:0]   magx_in, magy_in;
   logic               hit_ff, negx_ff, negy_ff;
   logic [W+DNW-1:0]   magx_ff, magy_ff;
   logic [DNW-1:0]     dn4_ff;
   logic [DNW-1:0]     gu;
   assign dxa     = dx[W] ? W'(-dx) : W'(dx);
   assign dya     = dy[W] ? W'(-dy) : W'(dy);
   assign gu      = gn_ff;
   assign magx_in = dxa * gu;
   assign magy_in = dya * gu;
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         hit_ff  <= cand_ff && !gn_ff[DNW-1] && (dn_ff >= gu);
         negx_ff <= dx[W];
         negy_ff <= dy[W];
         magx_ff <= magx_in;
         magy_ff <= magy_in;
         dn4_ff  <= dn_ff;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign hit       = hit_ff;
   assign negx      = negx_ff;
   assign negy      = negy_ff;
   assign magx      = magx_ff;
   assign magy      = magy_ff;
   assign dn        = dn4_ff;

endmodule

/* rtl/core/sit_div.sv */
// Pipelined rounding divider, one quotient bit per stage, x and y lanes
// sharing the denominator. Depends on sit_pkg.
module sit_div import sit_pkg::*; #(
   parameter int W = COORD_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic           hit,
   input  logic           negx,
   input  logic           negy,
   input  logic [3*W+3:0] magx,
   input  logic [3*W+3:0] magy,
   input  logic [2*W+3:0] dn,
   output logic           out_valid,
   input  logic           out_ready,
   output logic           out_hit,
   output logic           out_negx,
   output logic           out_negy,
   output logic [W:0]     qx,
   output logic [W:0]     qy
);
   localparam int NW  = 3 * W + 6;   // rounded numerator 2*mag + d
   localparam int DDW = 2 * W + 5;   // doubled denominator
   localparam int QB  = W + 1;       // quotient bits

   logic [NW-1:0]  nx_ff [QB+1];
   logic [NW-1:0]  ny_ff [QB+1];
   logic [DDW-1:0] dd_ff [QB+1];
   logic [QB-1:0]  qx_ff [QB+1];
   logic [QB-1:0]  qy_ff [QB+1];
   logic           hit_ff  [QB+1];
   logic           negx_ff [QB+1];
   logic           negy_ff [QB+1];
   logic [QB:0]    v_ff;
   logic [QB+1:0]  rdy;

   assign rdy[QB+1] = out_ready;
   for (genvar k = 0; k <= QB; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= QB; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // entry: round to nearest as floor((2*mag + d) / (2*d))
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         nx_ff[0]   <= NW'({magx, 1'b0}) + NW'(dn);
         ny_ff[0]   <= NW'({magy, 1'b0}) + NW'(dn);
         dd_ff[0]   <= {dn, 1'b0};
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         hit_ff[0]  <= hit;
         negx_ff[0] <= negx;
         negy_ff[0] <= negy;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int B = QB - 1 - k;
      logic [NW-1:0] sh;
      logic          gex, gey;
      assign sh  = NW'(dd_ff[k]) << B;
      assign gex = nx_ff[k] >= sh;
      assign gey = ny_ff[k] >= sh;
      always_ff @(posedge clock) begin
         if (rdy[k+1]) begin
            nx_ff[k+1]   <= gex ? nx_ff[k] - sh : nx_ff[k];
            ny_ff[k+1]   <= gey ? ny_ff[k] - sh : ny_ff[k];
            qx_ff[k+1]   <= qx_ff[k] | (QB'(gex) << B);
            qy_ff[k+1]   <= qy_ff[k] | (QB'(gey) << B);
            dd_ff[k+1]   <= dd_ff[k];
            hit_ff[k+1]  <= hit_ff[k];
            negx_ff[k+1] <= negx_ff[k];
            negy_ff[k+1] <= negy_ff[k];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_hit   = hit_ff[QB];
   assign out_negx  = negx_ff[QB];
   assign out_negy  = negy_ff[QB];
   assign qx        = qx_ff[QB];
   assign qy        = qy_ff[QB];

endmodule

/* rtl/core/segment_intersection_top.sv */
// Segment intersection top level: CSR bank, front pipeline, divider and
// output register. Depends on sit_pkg, sit_front and sit_div.
//
// Tests each probe segment on the request stream against a reference
// segment held in four CSRs and returns one response transaction per
// request: hit in rsp_tuser, and the crossing point (rounded to nearest,
// ties away from zero, same fixed-point format as the inputs) in
// rsp_tdata, zero when there is no hit. A zero-length reference never
// hits; touching an end of the reference counts as a hit. The block takes
// one transaction every cycle unless a full pipeline is held by rsp_tready.
// The pipeline has five front stages (differences, multipliers, cross
// products, sign fix, numerator multiply), COORD_BITS + 2 divider stages
// (entry stage, then one quotient bit each) and one output register. Every
// stage holds its own valid bit, so bubbles close up and the input keeps
// flowing while a response waits on rsp_tready, until the pipeline fills.
// CSRs must only be written while no transaction is in flight.
module segment_intersection_top import sit_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // csr write port
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_addr,
   input  logic [COORD_BITS-1:0]   csr_wdata,
   // request: probe_start_x, probe_start_y, probe_end_x, probe_end_y
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // response
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]      rsp_tdata,   // cross_x, cross_y
   output logic                                   rsp_tuser    // hit
);
   localparam int W      = COORD_BITS;
   localparam int RSP_TW = ((2 * COORD_BITS + 7) / 8) * 8;

   // reference segment CSRs
   logic signed [W-1:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ax0_ff <= '0;
         ay0_ff <= '0;
         ax1_ff <= '0;
         ay1_ff <= '0;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_START_X: ax0_ff <= csr_wdata;
            REG_START_Y: ay0_ff <= csr_wdata;
            REG_END_X:   ax1_ff <= csr_wdata;
            REG_END_Y:   ay1_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // reference direction; the user keeps it static with transactions in flight
   logic signed [W:0] dx, dy;
   assign dx = (W+1)'(ax1_ff) - (W+1)'(ax0_ff);
   assign dy = (W+1)'(ay1_ff) - (W+1)'(ay0_ff);

   // front pipeline
   logic            f_valid, f_ready, f_hit, f_negx, f_negy;
   logic [3*W+3:0]  f_magx, f_magy;
   logic [2*W+3:0]  f_dn;

   sit_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .p0x       (req_tdata[0*W +: W]),
      .p0y       (req_tdata[1*W +: W]),
      .p1x       (req_tdata[2*W +: W]),
      .p1y       (req_tdata[3*W +: W]),
      .ax0       (ax0_ff),
      .ay0       (ay0_ff),
      .dx        (dx),
      .dy        (dy),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .hit       (f_hit),
      .negx      (f_negx),
      .negy      (f_negy),
      .magx      (f_magx),
      .magy      (f_magy),
      .dn        (f_dn)
   );

   // divider pipeline
   logic         d_valid, d_ready, d_hit, d_negx, d_negy;
   logic [W:0]   d_qx, d_qy;

   sit_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .hit       (f_hit),
      .negx      (f_negx),
      .negy      (f_negy),
      .magx      (f_magx),
      .magy      (f_magy),
      .dn        (f_dn),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_hit   (d_hit),
      .out_negx  (d_negx),
      .out_negy  (d_negy),
      .qx        (d_qx),
      .qy        (d_qy)
   );

   // output stage: apply sign, add start point, zero on miss
   logic signed [W+1:0] offx, offy, sumx, sumy;
   assign offx = d_negx ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
   assign offy = d_negy ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
   assign sumx = (W+2)'(ax0_ff) + offx;
   assign sumy = (W+2)'(ay0_ff) + offy;

   logic          rsp_valid_ff, hit_ff;
   logic [W-1:0]  cx_ff, cy_ff;

   assign d_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (d_ready) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready) begin
         hit_ff <= d_hit;
         cx_ff  <= d_hit ? sumx[W-1:0] : '0;
         cy_ff  <= d_hit ? sumy[W-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = RSP_TW'({cy_ff, cx_ff});

endmodule

/* rtl/core/sit_checker.sv */
// Port-level checks for segment_intersection_top, attached by bind.
// Depends on sit_pkg.
module sit_checker import sit_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   input logic                               rsp_tuser
);

   // a miss carries a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero point");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a draining consumer never blocks the request side
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side ready");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind segment_intersection_top sit_checker #(.COORD_BITS(COORD_BITS)) u_sit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/segment_intersection_checker.sv */
`timescale 1ns / 1ps
// Checker for segment_intersection_top: watches the CSR port and both streams,
// predicts each response from the probe and the current reference, and compares.
// Depends on sit_pkg.
module segment_intersection_checker import sit_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_addr,
   input  logic [COORD_BITS-1:0]   csr_wdata,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                    rsp_tuser,
   input  logic                    test_done,
   output int                      pending_count,
   output int                      fail_count
);

   typedef struct packed {
      logic                  hit;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
   } crossing_t;

   logic [COORD_BITS-1:0] ref_pt [4];
   crossing_t             crossings_due [$];
   bit                    leftover_reported;

   initial fail_count = 0;
   assign pending_count = crossings_due.size();

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      fail_count++;
   endtask

   // n / den rounded to nearest, ties away from zero (den > 0)
   function automatic longint round_div(input longint n, input longint den);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q   = (2 * mag + den) / (2 * den);
      return (n < 0) ? -q : q;
   endfunction

   function automatic crossing_t predict_crossing(input logic [4*COORD_BITS-1:0] probe);
      longint    ax0, ay0, dx, dy, px0, py0, px1, py1, ex, ey, c0, c1, den, g;
      crossing_t r;
      ax0 = $signed(ref_pt[REG_START_X]);
      ay0 = $signed(ref_pt[REG_START_Y]);
      dx  = longint'($signed(ref_pt[REG_END_X])) - ax0;
      dy  = longint'($signed(ref_pt[REG_END_Y])) - ay0;
      px0 = $signed(probe[0*COORD_BITS +: COORD_BITS]);
      py0 = $signed(probe[1*COORD_BITS +: COORD_BITS]);
      px1 = $signed(probe[2*COORD_BITS +: COORD_BITS]);
      py1 = $signed(probe[3*COORD_BITS +: COORD_BITS]);
      ex  = px1 - px0;
      ey  = py1 - py0;
      c0  = dx * (py0 - ay0) - dy * (px0 - ax0);
      c1  = dx * (py1 - ay0) - dy * (px1 - ax0);
      r   = '0;
      if ((c0 < 0) != (c1 < 0)) begin
         den = c1 - c0;
         g   = ex * (ay0 - py0) - ey * (ax0 - px0);
         if (den < 0) begin
            den = -den;
            g   = -g;
         end
         if (g >= 0 && den >= g) begin
            r.hit = 1'b1;
            r.cx  = COORD_BITS'(ax0 + round_div(dx * g, den));
            r.cy  = COORD_BITS'(ay0 + round_div(dy * g, den));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      crossing_t want;
      if (reset) begin
         foreach (ref_pt[i]) ref_pt[i] <= '0;
      end else begin
         if (csr_we)
            ref_pt[csr_addr] <= csr_wdata;
         if (req_tvalid && req_tready)
            crossings_due.push_back(predict_crossing(req_tdata[4*COORD_BITS-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (crossings_due.size() == 0) begin
               report_mismatch("response with nothing outstanding");
            end else begin
               want = crossings_due.pop_front();
               if (rsp_tuser !== want.hit)
                  report_mismatch($sformatf("hit %b, want %b", rsp_tuser, want.hit));
               if (rsp_tdata[0 +: COORD_BITS] !== want.cx)
                  report_mismatch($sformatf("cross_x %0d, want %0d",
                     $signed(rsp_tdata[0 +: COORD_BITS]), $signed(want.cx)));
               if (rsp_tdata[COORD_BITS +: COORD_BITS] !== want.cy)
                  report_mismatch($sformatf("cross_y %0d, want %0d",
                     $signed(rsp_tdata[COORD_BITS +: COORD_BITS]), $signed(want.cy)));
            end
         end
         if (test_done && !leftover_reported && crossings_due.size() != 0) begin
            leftover_reported = 1;
            report_mismatch($sformatf("%0d responses never arrived", crossings_due.size()));
         end
      end
   end

endmodule

/* tb/sv/tb_segment_intersection_top.sv */
`timescale 1ns / 1ps
// Testbench top for segment_intersection_top: clock, reset, CSR phases and
// probe stimulus. Depends on sit_pkg, the DUT and segment_intersection_checker.
module tb_segment_intersection_top;
   import sit_pkg::*;

   localparam int CW        = COORD_BITS_DEF;
   localparam int LATENCY   = CW + 8;      // front, divider and output stages
   localparam int IDLE_PCT  = 32;
   localparam int HOLD_LEN  = 300;        // long receiver back-pressure stretch
   localparam int WDOG_MAX  = 4000;       // cycles with no transaction at all
   localparam int RAND_PER  = 180;        // random probes per reference setting

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_addr;
   logic [CW-1:0]           csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [63:0]             req_tdata;     // probe_start_x, probe_start_y, probe_end_x, probe_end_y
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [31:0]             rsp_tdata;     // cross_x, cross_y
   logic                    rsp_tuser;     // hit

   logic test_done;
   int   pending_count, fail_count;
   bit   no_idle;        // both sides stream back to back while set
   int   hold_reqs;      // bumped by the stimulus to ask for a receiver hold-off
   int   idle_cycles;

   // reference segment currently loaded (for aiming probes)
   int ref_ax0, ref_ay0, ref_ax1, ref_ay1;

   segment_intersection_top #(.COORD_BITS(CW)) u_dut (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   segment_intersection_checker #(.COORD_BITS(CW)) u_checker (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .test_done, .pending_count, .fail_count
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog: any accepted transaction restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random back-pressure, plus a long hold-off on request.
   always @(posedge clock) begin
      int hold_left, hold_seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
      end else begin
         if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // One request transaction; random idle cycles in front of it unless streaming.
   task automatic send_probe(input int x0, input int y0, input int x1, input int y1);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {CW'(y1), CW'(x1), CW'(y0), CW'(x0)};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain, let the pipe go quiet, then load a new reference segment.
   task automatic load_reference(input int ax0, input int ay0, input int ax1, input int ay1);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_START_X; csr_wdata <= CW'(ax0); @(posedge clock);
      csr_addr <= REG_START_Y; csr_wdata <= CW'(ay0); @(posedge clock);
      csr_addr <= REG_END_X;   csr_wdata <= CW'(ax1); @(posedge clock);
      csr_addr <= REG_END_Y;   csr_wdata <= CW'(ay1); @(posedge clock);
      csr_we <= 1'b0;
      ref_ax0 = ax0; ref_ay0 = ay0; ref_ax1 = ax1; ref_ay1 = ay1;
   endtask

   function automatic int rand_coord();
      return int'($signed(16'($urandom)));
   endfunction

   // Mostly probes aimed through a point on the reference, some pure noise.
   task automatic send_random_probe();
      int t, px, py, vx, vy, k, pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_probe(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else begin
         t  = $urandom_range(0, 256);
         px = ref_ax0 + (((ref_ax1 - ref_ax0) * t) >>> 8);
         py = ref_ay0 + (((ref_ay1 - ref_ay0) * t) >>> 8);
         if (pick < 40) begin
            // endpoint on the reference itself (end or line point)
            send_probe(px, py, rand_coord(), rand_coord());
         end else begin
            vx = $urandom_range(0, 800) - 400;
            vy = $urandom_range(0, 800) - 400;
            k  = $urandom_range(0, 3);
            send_probe(px + vx, py + vy, px - k * vx, py - k * vy);
         end
      end
   endtask

   // Directed probes against the current reference.
   task automatic send_directed();
      int mx, my;
      mx = (ref_ax0 + ref_ax1) / 2;
      my = (ref_ay0 + ref_ay1) / 2;
      send_probe(-32768, -32768, 32767, 32767);
      send_probe(32767, -32768, -32768, 32767);
      send_probe(-32768, 32767, 32767, -32768);
      send_probe(0, 0, 0, 0);
      send_probe(ref_ax0, ref_ay0, ref_ax1, ref_ay1);      // collinear
      send_probe(ref_ax0, ref_ay0 - 16, ref_ax0, ref_ay0 + 16);  // touches start
      send_probe(ref_ax1 - 16, ref_ay1, ref_ax1 + 16, ref_ay1);  // touches end
      send_probe(mx, my, mx + 100, my - 300);               // starts on the line
      send_probe(mx + 100, my - 300, mx, my);               // ends on the line
      send_probe(mx - 7, my + 9, mx + 7, my - 9);
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = REG_START_X;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      test_done  = 1'b0;
      no_idle    = 1'b0;
      hold_reqs  = 0;
      ref_ax0 = 0; ref_ay0 = 0; ref_ax1 = 0; ref_ay1 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset reference is zero length: nothing may hit.
      send_directed();
      repeat (40) send_random_probe();

      // Full-range diagonal, both sign extremes.
      load_reference(-32768, -32768, 32767, 32767);
      send_directed();
      repeat (RAND_PER) send_random_probe();

      // Opposite diagonal, streaming with a long receiver hold-off so the
      // pipe fills and req_tready drops.
      load_reference(32767, -32768, -32768, 32767);
      send_directed();
      no_idle   = 1'b1;
      hold_reqs = hold_reqs + 1;
      repeat (RAND_PER) send_random_probe();
      no_idle   = 1'b0;

      // Sender pauses until every response is back (done by the reload).
      load_reference(-80, 33, 1200, -517);
      send_directed();
      repeat (RAND_PER) send_random_probe();

      // Axis-aligned and random references.
      load_reference(-32768, 5, 32767, 5);
      send_directed();
      repeat (RAND_PER / 2) send_random_probe();
      load_reference(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      send_directed();
      repeat (RAND_PER) send_random_probe();

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      test_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
